// ===== sv/sie_pkg.sv =====
// Package: shared types, constants and the code byte layout of the encoder.
package sie_pkg;

   // Data bits carried by one code byte.
   localparam int unsigned GroupBits = 7;
   // Most bits that can stay in the accumulator between requests.
   localparam logic [2:0] HeldFull = 3'(GroupBits - 1);
   // Fewest data bits in a flushed byte that still set the marker bit.
   localparam logic [2:0] ForcedMinBits = 3'd3;

   // One queue entry: the one or two code bytes that a single request makes.
   typedef struct packed {
      logic [7:0] code0;
      logic [7:0] code1;
      logic       two;
      logic       last;
   } sie_entry_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } sie_qstat_type;

   // Place seven data bits around the marker bit at position 5.
   function automatic logic [7:0] spread_group(input logic [6:0] g, input logic forced);
      return {g[6:5], forced, g[4:0]};
   endfunction

endpackage

// ===== sv/sie_req_if.sv =====
// Interface: request channel carrying raw bytes into the encoder.
interface sie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       in_last;

   modport source (output valid, output data_byte, output in_last, input ready);
   modport sink (input valid, input data_byte, input in_last, output ready);
endinterface

// ===== sv/sie_rsp_if.sv =====
// Interface: response channel carrying encoded bytes out of the encoder.
interface sie_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       out_last;

   modport source (output valid, output code_byte, output out_last, input ready);
   modport sink (input valid, input code_byte, input out_last, output ready);
endinterface

// ===== sv/sie_front.sv =====
// Front end: accepts requests, repacks bits and builds queue entries.
module sie_front (
   input  logic                   clock,
   input  logic                   reset,
   sie_req_if.sink                req,
   input  sie_pkg::sie_qstat_type qstat,
   output logic                   push,
   output sie_pkg::sie_entry_type push_entry
);

   logic [5:0]  acc_ff, acc_in;
   logic [2:0]  held_ff, held_in;
   logic [13:0] w;
   logic [2:0]  sh;
   logic [7:0]  mask;
   logic [5:0]  rem;
   logic [6:0]  g1, g2;

   assign req.ready = !reset && !qstat.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      w    = (14'(acc_ff) << 8) | 14'(req.data_byte);
      sh   = held_ff + 3'd1;
      mask = ~(8'hFF << sh);
      rem  = 6'(req.data_byte & mask);
      push_entry = '0;
      if (held_ff == sie_pkg::HeldFull) begin
         // two full groups, nothing left over
         g1 = w[13:7];
         g2 = w[6:0];
         push_entry.code0 = sie_pkg::spread_group(g1, 1'b1);
         push_entry.code1 = sie_pkg::spread_group(g2, 1'b1);
         push_entry.two   = 1'b1;
         push_entry.last  = req.in_last;
         held_in = '0;
         acc_in  = '0;
      end else begin
         g1 = 7'(w >> sh);
         // left-align the leftover bits for a flush
         g2 = 7'({1'b0, rem} << (sie_pkg::HeldFull - held_ff));
         push_entry.code0 = sie_pkg::spread_group(g1, 1'b1);
         push_entry.code1 = sie_pkg::spread_group(g2, sh >= sie_pkg::ForcedMinBits);
         push_entry.two   = req.in_last;
         push_entry.last  = req.in_last;
         held_in = req.in_last ? 3'd0 : sh;
         acc_in  = req.in_last ? 6'd0 : rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
      end else if (push) begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== sv/sie_queue.sv =====
// Queue: short FIFO of entries between the front end and the back end.
module sie_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sie_pkg::sie_entry_type push_entry,
   input  logic                   pop,
   output sie_pkg::sie_entry_type head,
   output sie_pkg::sie_qstat_type qstat
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   sie_pkg::sie_entry_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CntFull);
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/sie_back.sv =====
// Back end: drains queue entries one code byte per cycle, while the consumer is ready, into the output register.
module sie_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sie_pkg::sie_entry_type head,
   input  sie_pkg::sie_qstat_type qstat,
   output logic                   pop,
   sie_rsp_if.source              rsp
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] code_ff, code_in;
   logic       last_ff, last_in;
   logic       sec_valid_ff, sec_valid_in;
   logic [7:0] sec_code_ff, sec_code_in;
   logic       sec_last_ff, sec_last_in;
   logic       take;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.code_byte = code_ff;
   assign rsp.out_last  = last_ff;

   always_comb begin
      take         = !rsp_valid_ff || rsp.ready;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      sec_valid_in = sec_valid_ff;
      sec_code_in  = sec_code_ff;
      sec_last_in  = sec_last_ff;
      if (take) begin
         if (sec_valid_ff) begin
            // second byte of the current entry goes next
            rsp_valid_in = 1'b1;
            code_in      = sec_code_ff;
            last_in      = sec_last_ff;
            sec_valid_in = 1'b0;
         end else if (!qstat.empty) begin
            pop          = 1'b1;
            rsp_valid_in = 1'b1;
            code_in      = head.code0;
            last_in      = head.last && !head.two;
            sec_valid_in = head.two;
            sec_code_in  = head.code1;
            sec_last_in  = head.last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
      code_ff     <= code_in;
      last_ff     <= last_in;
      sec_code_ff <= sec_code_in;
      sec_last_ff <= sec_last_in;
   end

endmodule

// ===== sv/seven_in_eight_visible_encoder_core.sv =====
// Top level: seven-in-eight visible encoder, front end, entry queue and back end.
//
// Usage:
//   req_chan carries raw bytes (data_byte) with in_last marking the final byte of a
//   message. rsp_chan carries code bytes: seven data bits each, MSB first, at bit
//   positions 7, 6 and 4..0, with bit 5 set. On the last request a leftover partial
//   group is flushed, zero padded, with bit 5 set only if it holds three or more data
//   bits; out_last marks the final code byte of the message.
//   Both channels use valid/ready; a request moves on an edge with both high.
//
// Data path and throughput:
//   The first code byte of a request passes through a queue entry and then the output
//   register. The response port delivers one code byte per cycle while the consumer
//   is ready; a request makes two code bytes on every seventh request, and on a last
//   request with bits left over, and one otherwise. The output port sets the rate.
//   Requests keep flowing while the queue (QUEUE_DEPTH entries) has room.
//
// Reset and stall:
//   Reset clears the bit accumulator, empties the queue and drops rsp valid; ready is
//   low while reset is high. A stalled response holds its byte; the queue fills and
//   then req ready falls until the consumer takes data again.
module seven_in_eight_visible_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   sie_req_if.sink   req_chan,
   sie_rsp_if.source rsp_chan
);

   sie_pkg::sie_entry_type push_entry;
   sie_pkg::sie_entry_type head;
   sie_pkg::sie_qstat_type qstat;
   logic                   push;
   logic                   pop;

   // Accept requests and repack them into one or two code bytes.
   sie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouple the two sides so each can stall on its own.
   sie_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // Drain entries a byte at a time into the response register.
   sie_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ===== sv/sie_checker.sv =====
// Checker: port-level assertions for the encoder, bound to the top level.
module sie_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] code_byte,
   input logic       out_last
);

   // A stalled response holds its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_byte) && $stable(out_last))
      else $error("stalled response changed");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only a flushed final byte may lack the marker bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_last |-> code_byte[5])
      else $error("marker bit clear on a full group");

   // A flush with fewer than three data bits has nothing below the marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_last && !code_byte[5] |-> code_byte[4:0] == 5'd0)
      else $error("short flush has data below marker");

endmodule

bind seven_in_eight_visible_encoder_core sie_checker u_sie_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .code_byte (rsp_chan.code_byte),
   .out_last  (rsp_chan.out_last)
);

// ===== verif/testbench.sv =====
// Testbench: random and directed requests through the encoder, checked against a predictor.
module testbench;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       in_last;
   } raw_req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       out_last;
   } code_rsp_type;

   localparam int unsigned LongHoldCycles = 250;

   logic clock;
   logic reset;

   sie_req_if req_if ();
   sie_rsp_if rsp_if ();

   seven_in_eight_visible_encoder_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Requests waiting to be offered, and code bytes predicted but not yet seen.
   raw_req_type  byte_q[$];
   code_rsp_type code_q[$];

   // Predictor state: leftover data bits, newest in the low end, and their count.
   logic [13:0] enc_bits  = '0;
   int unsigned enc_count = 0;

   // Idle odds in percent, long receiver hold-off, error tally.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   logic        hold_kick     = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned fail_count    = 0;

   raw_req_type offer;

   // Drive everything known from time zero, then toggle the clock.
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.in_last   = 1'b0;
      rsp_if.ready     = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up well past the slowest legal run.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   // Predict the code bytes of one accepted request and advance the bit state.
   task automatic encode_request(input raw_req_type req);
      logic [13:0]  window;
      logic [6:0]   group;
      int unsigned  held;
      int unsigned  made;
      code_rsp_type outs [2];
      window = ((enc_bits & ((14'd1 << enc_count) - 14'd1)) << 8) | 14'(req.data_byte);
      held   = enc_count + 8;
      made   = 0;
      // Emit every complete seven-bit group, oldest bits first.
      while (held >= sie_pkg::GroupBits && made < 2) begin
         group  = 7'(window >> (held - sie_pkg::GroupBits));
         held   = held - sie_pkg::GroupBits;
         window = window & ((14'd1 << held) - 14'd1);
         outs[made] = '{code_byte: {group[6:5], 1'b1, group[4:0]}, out_last: 1'b0};
         made++;
      end
      if (req.in_last) begin
         if (held > 0) begin
            // Flush the leftover bits left-aligned; the marker needs three data bits.
            group = 7'((window & ((14'd1 << held) - 14'd1)) << (sie_pkg::GroupBits - held));
            outs[made] = '{code_byte: {group[6:5], 1'(held >= 3), group[4:0]},
                           out_last: 1'b1};
            made++;
         end else begin
            // Nothing left over: the last full group closes the message.
            outs[made - 1].out_last = 1'b1;
         end
         window = '0;
         held   = 0;
      end
      for (int i = 0; i < made; i++) code_q.push_back(outs[i]);
      enc_bits  = window;
      enc_count = held;
   endtask

   // Driver: predict on acceptance, then offer the next request or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         enc_bits  = '0;
         enc_count = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            encode_request(offer);
         end
         // Hold the current request until it is taken.
         if (!req_if.valid || req_if.ready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer = byte_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.data_byte <= offer.data_byte;
               req_if.in_last   <= offer.in_last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Count down a long receiver hold-off once kicked.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= LongHoldCycles;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare each taken code byte with the oldest prediction, then set ready.
   always @(posedge clock) begin
      code_rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (code_q.size() == 0) begin
               $display("%0t: unexpected code byte: expected none, actual %h last %b",
                        $time, rsp_if.code_byte, rsp_if.out_last);
               fail_count++;
            end else begin
               want = code_q.pop_front();
               if (rsp_if.code_byte !== want.code_byte) begin
                  $display("%0t: code_byte mismatch: expected %h, actual %h",
                           $time, want.code_byte, rsp_if.code_byte);
                  fail_count++;
               end
               if (rsp_if.out_last !== want.out_last) begin
                  $display("%0t: out_last mismatch: expected %b, actual %b",
                           $time, want.out_last, rsp_if.out_last);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Queue random messages: mostly runs of one to 24 bytes, some one- and two-byte noise.
   task automatic queue_messages(input int n_items);
      int         left;
      int         len;
      int         pick;
      logic [7:0] value;
      left = n_items;
      while (left > 0) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 24);
         for (int i = 0; i < len; i++) begin
            pick  = $urandom_range(15);
            value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            byte_q.push_back('{data_byte: value, in_last: 1'(i == len - 1)});
         end
         left -= len;
      end
   endtask

   // Wait until every request is taken and every code byte has come back.
   task automatic drain_all();
      while (byte_q.size() != 0 || req_if.valid || code_q.size() != 0) @(negedge clock);
   endtask

   // Stimulus sequence; all changes land on the falling edge, clear of the driver.
   initial begin
      logic [7:0] value;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Phase one: sender idles lightly, receiver heavily.
      send_idle_pct = 18;
      rsp_idle_pct  = 45;

      // Messages of one to seven bytes leave one to six bits over, then none,
      // so the flush covers short groups with and without the marker bit.
      for (int len = 1; len <= 7; len++) begin
         for (int k = 0; k < len; k++) begin
            if (len % 2 == 1) value = (k % 2 == 1) ? 8'h00 : 8'hFF;
            else              value = (k % 2 == 1) ? 8'h55 : 8'hAA;
            byte_q.push_back('{data_byte: value, in_last: 1'(k == len - 1)});
         end
      end
      queue_messages(660);

      // Stall the receiver long enough to fill the queue and drop req ready.
      repeat (20) @(negedge clock);
      hold_kick = 1'b1;
      @(negedge clock);
      hold_kick = 1'b0;
      drain_all();

      // Phase two: roles swapped; the drain above paused the sender.
      send_idle_pct = 45;
      rsp_idle_pct  = 18;
      queue_messages(660);
      drain_all();

      // Phase three: full rate on both sides.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      queue_messages(660);
      drain_all();

      // Let any stray code byte show up before the verdict.
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
